@@ hw/rtl/sdbi_pkg.sv @@
// package for the srrip dead-block insertion unit
// constants and a set-line type; no dependencies
`default_nettype none
package sdbi_pkg;
  localparam int WAYS = 16;
  localparam int SETS = 1024;
  localparam int MAX_RRPV_BITS = 4;
  localparam int WAY_W = 4;
  localparam int SET_W = 10;
  localparam int RRPV_W = 4;
  localparam int LINE_W = WAYS * RRPV_W;
  localparam logic [13:0] DEAD_SCALE = 14'd10000;
  localparam logic [1:0] REG_RRPV_BITS = 2'd0;
  localparam logic [1:0] REG_DEAD_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SAMPLE_LIMIT = 2'd2;

  // per-set record: rrpv, reused, owner of every way, plus scan pointer
  typedef struct packed {
    logic [WAYS-1:0][RRPV_W-1:0] rrpv;
    logic [WAYS-1:0] reused;
    logic [WAYS-1:0] owner;
    logic [WAY_W-1:0] ptr;
  } set_line_t;
endpackage
`default_nettype wire

@@ hw/rtl/sdbi_set_ram.sv @@
// set-line memory, swept to its reset contents by the sequencer's clearing pass
// depends on sdbi_pkg
`default_nettype none
module sdbi_set_ram
  import sdbi_pkg::*;
(
  input  wire logic clk,
  input  wire logic clr_en,
  input  wire logic [SET_W-1:0] clr_addr,
  input  wire logic rd_en,
  input  wire logic [SET_W-1:0] rd_addr,
  output set_line_t rd_data,
  input  wire logic wr_en,
  input  wire logic [SET_W-1:0] wr_addr,
  input  set_line_t wr_data
);
  set_line_t mem [SETS];
  set_line_t init_line;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      init_line.rrpv[i] = RRPV_W'(2);
    end
    init_line.reused = '0;
    init_line.owner = '0;
    init_line.ptr = '0;
  end

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_addr] <= init_line;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/srrip_dead_block_dynamic_insertion_unit.sv @@
// top level: srrip replacement with dead-block driven insertion
// depends on sdbi_pkg and sdbi_set_ram
`default_nettype none
// a miss result strobes after S_READ and S_SCAN, with S_SCAN repeated for each aging round
// busy until the set is written back; a hit passes through S_READ, an empty fill through S_READ
//   and S_SCAN, an eviction also through S_CHK1 and S_CHK0 after its aging rounds
// reset: after rst a clearing pass sweeps all 1024 sets of the set memory, busy high meanwhile
module srrip_dead_block_dynamic_insertion_unit
  import sdbi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic req_type,
  input  wire logic [9:0] set_index,
  input  wire logic [3:0] hit_way,
  input  wire logic core_id,
  input  wire logic [15:0] valid_mask,
  output logic done,
  output logic [3:0] victim_way,
  output logic filled_empty,
  output logic evicted_dead,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_SCAN, S_CHK1, S_CHK0}
    state_t;
  state_t state;

  logic [2:0] rrpv_bits;
  logic [13:0] dead_threshold;
  logic [15:0] sample_limit;
  logic [RRPV_W-1:0] ins0, ins1;
  logic [15:0] fills0, fills1, dead0, dead1;

  logic req_q, core_q;
  logic [SET_W-1:0] set_q;
  logic [WAY_W-1:0] way_q;
  logic [15:0] valid_q;
  logic [SET_W-1:0] clr_cnt;
  set_line_t line, rd_line, wr_line, wr_line_next;
  logic wr_en, rd_en;

  // a pending write-back keeps the unit busy so the next read sees it
  assign busy = (state != S_IDLE) || wr_en;
  assign cfg_ready = !busy;
  assign rd_en = start && !busy;

  // effective max rrpv
  logic [2:0] bits_eff;
  logic [RRPV_W-1:0] mx;
  always_comb begin
    bits_eff = rrpv_bits;
    if (bits_eff == 3'd0) bits_eff = 3'd1;
    if (bits_eff > 3'(MAX_RRPV_BITS)) bits_eff = 3'(MAX_RRPV_BITS);
    mx = RRPV_W'((5'd1 << bits_eff) - 5'd1);
  end

  sdbi_set_ram u_ram (
    .clk(clk),
    .clr_en(state == S_CLEAR), .clr_addr(clr_cnt),
    .rd_en(rd_en), .rd_addr(set_index), .rd_data(rd_line),
    .wr_en(wr_en), .wr_addr(set_q), .wr_data(wr_line)
  );

  // circular search from the pointer for a way at or above max
  logic found;
  logic [WAY_W-1:0] fway;
  always_comb begin
    logic [WAY_W-1:0] w;
    found = 1'b0;
    fway = line.ptr;
    for (int k = WAYS - 1; k >= 0; k--) begin
      w = line.ptr + WAY_W'(k);
      if (line.rrpv[w] >= mx) begin
        found = 1'b1;
        fway = w;
      end
    end
  end

  // first invalid way
  logic any_inv;
  logic [WAY_W-1:0] inv_way;
  always_comb begin
    any_inv = 1'b0;
    inv_way = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(k);
      end
    end
  end

  // dead test: one pair of 16x14 multipliers shared by both cores, one core per cycle
  logic [15:0] m_dead, m_fill;
  logic dead_hit;
  always_comb begin
    m_dead = (state == S_CHK1) ? dead1 : dead0;
    m_fill = (state == S_CHK1) ? fills1 : fills0;
    dead_hit = (30'(m_dead) * 30'(DEAD_SCALE)) >= (30'(dead_threshold) * 30'(m_fill));
  end

  logic [RRPV_W-1:0] ins_sel;
  assign ins_sel = core_q ? ins1 : ins0;

  // write-back line: hit promotion after the read, or the fill after the scan
  always_comb begin
    wr_line_next = line;
    if (state == S_READ) begin
      wr_line_next = rd_line;
      wr_line_next.rrpv[way_q] = '0;
      wr_line_next.reused[way_q] = 1'b1;
    end else if (any_inv) begin
      wr_line_next.rrpv[inv_way] = ins_sel;
      wr_line_next.reused[inv_way] = 1'b0;
      wr_line_next.owner[inv_way] = core_q;
    end else begin
      wr_line_next.rrpv[fway] = ins_sel;
      wr_line_next.reused[fway] = 1'b0;
      wr_line_next.owner[fway] = core_q;
      wr_line_next.ptr = fway + 1'b1;
    end
  end

  logic scan_fill, hit_wr;
  assign scan_fill = (state == S_SCAN) && (any_inv || found);
  assign hit_wr = (state == S_READ) && !req_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      done <= 1'b0;
      wr_en <= 1'b0;
      rrpv_bits <= 3'd2;
      dead_threshold <= 14'd9000;
      sample_limit <= 16'd1024;
      ins0 <= RRPV_W'(2);
      ins1 <= RRPV_W'(2);
      fills0 <= '0;
      fills1 <= '0;
      dead0 <= '0;
      dead1 <= '0;
    end else begin
      done <= scan_fill;
      wr_en <= scan_fill || hit_wr;
      wr_line <= wr_line_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RRPV_BITS: rrpv_bits <= cfg_data[2:0];
          REG_DEAD_THRESHOLD: dead_threshold <= cfg_data[13:0];
          REG_SAMPLE_LIMIT: sample_limit <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SET_W'(SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start && !busy) begin
            req_q <= req_type;
            set_q <= set_index;
            way_q <= hit_way;
            core_q <= core_id;
            valid_q <= valid_mask;
            state <= S_READ;
          end
        end
        S_READ: begin
          line <= rd_line;
          state <= req_q ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          if (any_inv) begin
            victim_way <= inv_way;
            filled_empty <= 1'b1;
            evicted_dead <= 1'b0;
            state <= S_IDLE;
          end else if (found) begin
            victim_way <= fway;
            filled_empty <= 1'b0;
            evicted_dead <= !line.reused[fway];
            if (!line.reused[fway]) begin
              if (!line.owner[fway]) begin
                if (dead0 != 16'hFFFF) dead0 <= dead0 + 1'b1;
              end else begin
                if (dead1 != 16'hFFFF) dead1 <= dead1 + 1'b1;
              end
            end
            if (core_q) fills1 <= fills1 + 1'b1;
            else fills0 <= fills0 + 1'b1;
            state <= S_CHK1;
          end else begin
            // age every way below max by one
            for (int i = 0; i < WAYS; i++) begin
              if (line.rrpv[i] < mx) line.rrpv[i] <= line.rrpv[i] + 1'b1;
            end
          end
        end
        S_CHK1: begin
          if (fills1 == sample_limit) begin
            ins1 <= (dead_hit && ins0 != mx) ? mx : mx - 1'b1;
            fills1 <= '0;
            dead1 <= '0;
          end
          state <= S_CHK0;
        end
        S_CHK0: begin
          if (fills0 == sample_limit) begin
            ins0 <= (dead_hit && ins1 != mx) ? mx : mx - 1'b1;
            fills0 <= '0;
            dead0 <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sdbi_checker.sv @@
// port-level checker for the insertion unit, bound to the top level
// depends on srrip_dead_block_dynamic_insertion_unit
`default_nettype none
module sdbi_props (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic filled_empty,
  input wire logic evicted_dead
);
  // no result without a transaction in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result outside transaction");
  // an accepted transaction makes the unit busy
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept without busy");
  // empty fill never reports a dead eviction
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (done && filled_empty) |-> !evicted_dead) else $error("dead on empty fill");
  // results are single-cycle pulses
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
endmodule

bind srrip_dead_block_dynamic_insertion_unit sdbi_props u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .filled_empty(filled_empty), .evicted_dead(evicted_dead)
);
`default_nettype wire

@@ tb/sdbi_checker.sv @@
// checker for the srrip dead-block insertion unit: mirrors the policy state,
// predicts each miss outcome and compares it with the done strobe; uses sdbi_pkg
`timescale 1ns / 100ps
module sdbi_checker
  import sdbi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  wire logic req_type,
  input  wire logic [9:0] set_index,
  input  wire logic [3:0] hit_way,
  input  wire logic core_id,
  input  wire logic [15:0] valid_mask,
  input  wire logic done,
  input  wire logic [3:0] victim_way,
  input  wire logic filled_empty,
  input  wire logic evicted_dead,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  output int errors,
  output int pending,
  output int misses_seen
);
  typedef struct packed {
    logic [3:0] way;
    logic       empty;
    logic       dead;
  } fill_outcome_t;

  fill_outcome_t outcome_q[$];
  logic [3:0] rrpv_m[SETS*WAYS];
  logic       reused_m[SETS*WAYS];
  logic       owner_m[SETS*WAYS];
  logic [3:0] ptr_m[SETS];
  logic [3:0] ins_pos[2];
  logic [15:0] fills[2];
  logic [15:0] deads[2];
  logic [2:0]  bits_r;
  logic [13:0] thr_r;
  logic [15:0] limit_r;

  assign pending = outcome_q.size();

  function automatic logic [3:0] max_rrpv();
    int b;
    b = bits_r;
    if (b < 1) b = 1;
    if (b > MAX_RRPV_BITS) b = MAX_RRPV_BITS;
    return 4'((1 << b) - 1);
  endfunction

  // end of a sampling phase for core c
  task automatic close_phase(int c);
    logic [3:0] mx;
    logic [63:0] lhs, rhs;
    mx = max_rrpv();
    if (fills[c] == limit_r) begin
      lhs = 64'(deads[c]) * 64'(DEAD_SCALE);
      rhs = 64'(thr_r) * 64'(fills[c]);
      if (lhs >= rhs && ins_pos[1-c] != mx) ins_pos[c] = mx;
      else ins_pos[c] = mx - 4'd1;
      fills[c] = '0;
      deads[c] = '0;
    end
  endtask

  task automatic predict_miss(int s, int c, logic [15:0] vm);
    fill_outcome_t o;
    logic [3:0] mx, ins, ptr, vic;
    int base, w;
    bit found;
    mx = max_rrpv();
    ins = ins_pos[c];
    base = s * WAYS;
    for (w = 0; w < WAYS; w++)
      if (!vm[w]) begin
        rrpv_m[base+w] = ins;
        reused_m[base+w] = 0;
        owner_m[base+w] = c[0];
        o = '{way: 4'(w), empty: 1'b1, dead: 1'b0};
        outcome_q.push_back(o);
        return;
      end
    ptr = ptr_m[s];
    vic = ptr;
    found = 0;
    for (int r = 0; r <= mx && !found; r++) begin
      for (int k = 0; k < WAYS && !found; k++)
        if (rrpv_m[base + ((ptr + k) % WAYS)] >= mx) begin
          vic = 4'((ptr + k) % WAYS);
          found = 1;
        end
      if (!found)
        for (w = 0; w < WAYS; w++)
          if (rrpv_m[base+w] < mx) rrpv_m[base+w]++;
    end
    ptr_m[s] = vic + 4'd1;
    o = '{way: vic, empty: 1'b0, dead: !reused_m[base+vic]};
    if (o.dead) begin
      if (deads[owner_m[base+vic]] != 16'hFFFF) deads[owner_m[base+vic]]++;
    end
    rrpv_m[base+vic] = ins;
    fills[c]++;
    reused_m[base+vic] = 0;
    owner_m[base+vic] = c[0];
    close_phase(1);
    close_phase(0);
    outcome_q.push_back(o);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS*WAYS; i++) begin
        rrpv_m[i] = 4'd2;
        reused_m[i] = 0;
        owner_m[i] = 0;
      end
      for (int i = 0; i < SETS; i++) ptr_m[i] = '0;
      ins_pos = '{4'd2, 4'd2};
      fills = '{16'd0, 16'd0};
      deads = '{16'd0, 16'd0};
      bits_r = 3'd2;
      thr_r = 14'd9000;
      limit_r = 16'd1024;
      errors = 0;
      misses_seen = 0;
      outcome_q.delete();
    end else begin
      // result strobe first: it belongs to an earlier transaction
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result: way %0d", victim_way);
          errors++;
        end else begin
          fill_outcome_t e;
          e = outcome_q.pop_front();
          misses_seen++;
          if (victim_way !== e.way) begin
            $error("victim_way expected %0d actual %0d", e.way, victim_way);
            errors++;
          end
          if (filled_empty !== e.empty) begin
            $error("filled_empty expected %0b actual %0b", e.empty, filled_empty);
            errors++;
          end
          if (evicted_dead !== e.dead) begin
            $error("evicted_dead expected %0b actual %0b", e.dead, evicted_dead);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          REG_RRPV_BITS:      bits_r = cfg_data[2:0];
          REG_DEAD_THRESHOLD: thr_r = cfg_data[13:0];
          REG_SAMPLE_LIMIT:   limit_r = cfg_data;
          default: ;
        endcase
      if (start && !busy) begin
        if (!req_type) begin
          reused_m[set_index*WAYS + hit_way] = 1;
          rrpv_m[set_index*WAYS + hit_way] = '0;
        end else begin
          predict_miss(set_index, core_id, valid_mask);
        end
      end
    end
  end
endmodule

@@ tb/tb_srrip_dead_block_dynamic_insertion_unit.sv @@
// testbench top for srrip_dead_block_dynamic_insertion_unit: drives requests
// and register writes; checking lives in sdbi_checker; uses sdbi_pkg
`timescale 1ns / 100ps
module tb_srrip_dead_block_dynamic_insertion_unit;
  import sdbi_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic req_type = 0;
  logic [9:0] set_index = '0;
  logic [3:0] hit_way = '0;
  logic core_id = 0;
  logic [15:0] valid_mask = '0;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic busy, done, filled_empty, evicted_dead, cfg_ready;
  logic [3:0] victim_way;
  int errors, pending, misses_seen;
  int idle_pct = 18;
  int requests_sent = 0;
  int quiet_cycles = 0;

  localparam int QUIET_LIMIT = 20000;

  always #6 clk = ~clk;

  srrip_dead_block_dynamic_insertion_unit uut (
    .clk, .rst, .start, .busy, .req_type, .set_index, .hit_way, .core_id,
    .valid_mask, .done, .victim_way, .filled_empty, .evicted_dead,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sdbi_checker chk (
    .clk, .rst, .start, .busy, .req_type, .set_index, .hit_way, .core_id,
    .valid_mask, .done, .victim_way, .filled_empty, .evicted_dead,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .misses_seen
  );

  // watchdog: cycles with no accepted transaction, register write or result; clearing pass allowed for
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // one request transaction; start stays high into the next one unless it idles
  task automatic send_req(bit miss, int s, int w, bit c, logic [15:0] vm);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    req_type <= miss;
    set_index <= 10'(s);
    hit_way <= 4'(w);
    core_id <= c;
    valid_mask <= vm;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // wait for outstanding results, then the worst-case miss latency
  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // random traffic over a handful of sets so ways fill, age and get evicted
  task automatic random_block(int n);
    int s;
    logic [15:0] vm;
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(7);
      case ($urandom_range(9))
        0: vm = 16'($urandom);
        1: vm = 16'hFFFF & ~(16'd1 << $urandom_range(15));
        default: vm = 16'hFFFF;
      endcase
      send_req($urandom_range(2) != 0, s, $urandom_range(15), $urandom_range(1), vm);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty fills, full-set evictions, hits, set and way extremes
    send_req(1, 0, 0, 0, 16'h0000);
    send_req(1, 0, 0, 1, 16'h0001);
    send_req(1, 1023, 0, 1, 16'h7FFF);
    send_req(1, 1023, 0, 0, 16'hFFFF);
    send_req(0, 1023, 15, 0, 16'hFFFF);
    send_req(0, 0, 0, 1, 16'h0000);
    send_req(1, 0, 0, 0, 16'hFFFF);
    send_req(0, 5, 3, 0, 16'h0000);
    send_req(1, 5, 9, 1, 16'hFFFF);
    send_req(1, 5, 9, 1, 16'hFFFF);
    drain();

    // widest rrpv with a tiny phase, then shrink to leave stale values
    write_reg(REG_RRPV_BITS, 16'd4);
    write_reg(REG_SAMPLE_LIMIT, 16'd1);
    write_reg(REG_DEAD_THRESHOLD, 16'd0);
    for (int i = 0; i < 6; i++) send_req(1, 2, 0, i[0], 16'hFFFF);
    drain();
    write_reg(REG_RRPV_BITS, 16'd1);
    write_reg(REG_DEAD_THRESHOLD, 16'd10000);
    for (int i = 0; i < 6; i++) send_req(1, 2, 0, i[0], 16'hFFFF);
    drain();
    // out-of-range rrpv widths
    write_reg(REG_RRPV_BITS, 16'd0);
    send_req(1, 3, 0, 0, 16'hFFFF);
    drain();
    write_reg(REG_RRPV_BITS, 16'd7);
    send_req(1, 3, 0, 1, 16'hFFFF);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 18 : (ph < 4) ? 65 : 0;
      write_reg(REG_RRPV_BITS, 16'($urandom_range(7)));
      write_reg(REG_DEAD_THRESHOLD, 16'($urandom_range(10000)));
      case (ph)
        0: write_reg(REG_SAMPLE_LIMIT, 16'd0);
        1: write_reg(REG_SAMPLE_LIMIT, 16'd65535);
        default: write_reg(REG_SAMPLE_LIMIT, 16'($urandom_range(1, 40)));
      endcase
      random_block(110);
      drain();
    end

    $display("covered %0d requests, %0d miss results checked, six random phases",
             requests_sent, misses_seen);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
